FILE: src/bsfr_pkg.sv
// Shared types, byte codes and the FCS-16 step for the byte-stuffed frame receiver.
// No dependencies; every file of the block but bsfr_ram imports this package.
package bsfr_pkg;

	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [7:0]  ESC_BYTE  = 8'h7D;
	localparam logic [7:0]  ESC_XOR   = 8'h20;
	localparam logic [15:0] FCS_INIT  = 16'hFFFF;
	localparam logic [15:0] FCS_POLY  = 16'h8408;
	localparam logic [15:0] FCS_GOOD  = 16'hF0B8;
	localparam int          LEN_W     = 6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;        // input item accepted this cycle
		logic start_emit;  // good closing flag: latch length, read first entry
		logic advance;     // output item taken and more remain: read next entry
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic frame_good;  // current rx_byte closes a frame with good FCS and length
		logic last_byte;   // entry on the output is the final payload byte
	} dp_status_t;

	// One byte through the reflected CCITT FCS-16, LSB first.
	function automatic logic [15:0] fcs_step(input logic [15:0] fcs, input logic [7:0] b);
		logic [15:0] v;
		v = fcs ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (v[0]) begin
				v = (v >> 1) ^ FCS_POLY;
			end else begin
				v = v >> 1;
			end
		end
		return v;
	endfunction

endpackage

FILE: src/byte_stuffed_frame_receiver.sv
// Byte-stuffed frame receiver: one received byte per cycle while receiving.
// A good closing flag shows the first payload byte in the next cycle, then one
// byte per cycle while out_ready is high; input is held off until the final
// payload byte is taken. The frame store is one RAM port pair. arst_n clears
// control state at once; the store is not cleared.
module byte_stuffed_frame_receiver #(
	parameter int FRAME_BYTES = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 rx_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 payload_byte,
	output logic [bsfr_pkg::LEN_W-1:0] frame_length,
	output logic                       last
);

	import bsfr_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	bsfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	bsfr_dp #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (rx_byte),
		.cmd         (cmd),
		.status      (status),
		.payload_byte(payload_byte),
		.frame_length(frame_length)
	);

	assign last = status.last_byte;

endmodule

FILE: src/bsfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/bsfr_dp.sv
// Datapath: unstuffing, fill count, running FCS, frame store and readout pointer.
// Depends on bsfr_pkg and bsfr_ram.
module bsfr_dp #(
	parameter int FRAME_BYTES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [7:0]                  rx_byte,
	input  bsfr_pkg::dp_cmd_t           cmd,
	output bsfr_pkg::dp_status_t        status,
	output logic [7:0]                  payload_byte,
	output logic [bsfr_pkg::LEN_W-1:0]  frame_length
);

	import bsfr_pkg::*;

	localparam int AW = $clog2(FRAME_BYTES);
	localparam int FW = $clog2(FRAME_BYTES + 1);
	localparam logic [FW-1:0] FULL = FW'(FRAME_BYTES);

	logic [FW-1:0] fill_q;
	logic          in_frame_q;
	logic          esc_q;
	logic [15:0]   fcs_q;
	logic [FW-1:0] len_q;
	logic [AW-1:0] rd_ptr_q;

	logic          is_flag;
	logic          is_esc;
	logic [7:0]    data_byte;
	logic          store_en;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	assign is_flag   = (rx_byte == FLAG_BYTE);
	assign is_esc    = (rx_byte == ESC_BYTE);
	assign data_byte = esc_q ? (rx_byte ^ ESC_XOR) : rx_byte;
	assign store_en  = cmd.take && in_frame_q && !is_flag && !is_esc && (fill_q != FULL);

	assign status.frame_good = is_flag && in_frame_q && (fill_q >= FW'(3)) && (fcs_q == FCS_GOOD);
	assign status.last_byte  = ((FW'(rd_ptr_q) + FW'(1)) == len_q);

	assign rd_en   = cmd.start_emit || cmd.advance;
	assign rd_addr = cmd.start_emit ? '0 : rd_ptr_q + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			fcs_q      <= FCS_INIT;
		end else if (cmd.take) begin
			if (is_flag) begin
				in_frame_q <= !in_frame_q;
				fill_q     <= '0;
				esc_q      <= 1'b0;
				if (!in_frame_q) begin
					fcs_q <= FCS_INIT;
				end
			end else if (in_frame_q) begin
				if (is_esc) begin
					esc_q <= 1'b1;
				end else begin
					esc_q <= 1'b0;
					if (fill_q == FULL) begin
						// overflow: abort and wait for a new opening flag
						in_frame_q <= 1'b0;
						fill_q     <= '0;
					end else begin
						fill_q <= fill_q + FW'(1);
						fcs_q  <= fcs_step(fcs_q, data_byte);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			rd_ptr_q <= '0;
		end else if (cmd.start_emit) begin
			len_q    <= fill_q - FW'(2);
			rd_ptr_q <= '0;
		end else if (cmd.advance) begin
			rd_ptr_q <= rd_addr;
		end
	end

	bsfr_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_BYTES)
	) u_store (
		.clk  (clk),
		.we   (store_en),
		.waddr(fill_q[AW-1:0]),
		.wdata(data_byte),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(payload_byte)
	);

	assign frame_length = LEN_W'(len_q);

endmodule

FILE: src/bsfr_ctrl.sv
// Controller: alternates between taking input items and streaming a good frame out.
// Depends on bsfr_pkg.
module bsfr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  bsfr_pkg::dp_status_t status,
	output bsfr_pkg::dp_cmd_t    cmd
);

	import bsfr_pkg::*;

	typedef enum logic [1:0] {
		ST_RECV = 2'b01,
		ST_SEND = 2'b10
	} state_t;

	state_t state_q;
	logic   take;
	logic   out_take;

	assign in_ready  = (state_q == ST_RECV);
	assign out_valid = (state_q == ST_SEND);
	assign take      = in_valid && in_ready;
	assign out_take  = out_valid && out_ready;

	assign cmd.take       = take;
	assign cmd.start_emit = take && status.frame_good;
	assign cmd.advance    = out_take && !status.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RECV;
		end else begin
			case (state_q)
				ST_RECV: begin
					if (take && status.frame_good) begin
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					// hold input until the final byte is taken
					if (out_take && status.last_byte) begin
						state_q <= ST_RECV;
					end
				end
				default: begin
					state_q <= ST_RECV;
				end
			endcase
		end
	end

endmodule

FILE: src/bsfr_checker.sv
// Port-level checks for the byte-stuffed frame receiver, bound to the top level.
// Depends on bsfr_pkg.
module bsfr_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic [7:0]                 rx_byte,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [7:0]                 payload_byte,
	input logic [bsfr_pkg::LEN_W-1:0] frame_length,
	input logic                       last
);

	import bsfr_pkg::*;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a frame is streaming out");

	a_len_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && $stable(frame_length))
		else $error("frame ended early or length changed within a frame");

	a_back_to_recv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> in_ready && !out_valid)
		else $error("receiver did not resume after the final item");

	a_only_flag_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (rx_byte != FLAG_BYTE) |=> !out_valid)
		else $error("output started without a closing flag");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(last))
		else $error("stalled output item changed");

endmodule

bind byte_stuffed_frame_receiver bsfr_checker u_bsfr_checker (.*);
